### hw/rtl/u16550_pkg.sv
// Shared definitions for the 16550-style UART register file.
// Holds register offsets, field codes, fixed register values and the
// structs passed between the register block and the receive FIFO.
`default_nettype none

package u16550_pkg;

  localparam int RX_DEPTH_DEF = 64;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [2:0] OFS_RBR = 3'd0;
  localparam logic [2:0] OFS_IER = 3'd1;
  localparam logic [2:0] OFS_IIR = 3'd2;
  localparam logic [2:0] OFS_LCR = 3'd3;
  localparam logic [2:0] OFS_MCR = 3'd4;
  localparam logic [2:0] OFS_LSR = 3'd5;
  localparam logic [2:0] OFS_MSR = 3'd6;
  localparam logic [2:0] OFS_SCR = 3'd7;

  localparam int LCR_DLAB_BIT   = 7;
  localparam int MCR_LOOP_BIT   = 4;
  localparam int FCR_CLR_RX_BIT = 1;
  localparam int IER_RX_BIT     = 0;
  localparam int IER_TX_BIT     = 1;

  localparam logic [3:0] IIR_NONE = 4'h1;
  localparam logic [3:0] IIR_TX   = 4'h2;
  localparam logic [3:0] IIR_RX   = 4'h4;

  localparam logic [7:0] IIR_FIXED     = 8'hC0;
  localparam logic [7:0] MSR_FIXED     = 8'hB0;
  localparam logic [7:0] MCR_RESET     = 8'h08;
  localparam logic [7:0] LSR_TEMT_THRE = 8'h60;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } fifo_req_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       one_left;
    logic [7:0] head;
  } fifo_stat_t;

  typedef struct packed {
    logic       irq_level;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/u16550_rx_fifo.sv
// Receive FIFO of the UART register file: storage, fill and take counts.
// The head entry is read ahead into a register so it is ready for a pop.
// Depends on u16550_pkg.
`default_nettype none

module u16550_rx_fifo #(
  parameter int RX_DEPTH = u16550_pkg::RX_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  u16550_pkg::fifo_req_t  req,
  output u16550_pkg::fifo_stat_t stat
);

  localparam int CW = $clog2(RX_DEPTH + 1);
  localparam int AW = $clog2(RX_DEPTH);

  logic [7:0]    mem [RX_DEPTH];
  logic [7:0]    head_q;
  logic [CW-1:0] fill;
  logic [CW-1:0] take;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] take_next;
  logic          one_left;

  assign one_left = (take + CW'(1)) == fill;

  always_comb begin
    fill_next = fill;
    take_next = take;
    if (req.clear) begin
      fill_next = '0;
      take_next = '0;
    end else if (req.push) begin
      fill_next = fill + CW'(1);
    end else if (req.pop) begin
      if (one_left) begin
        fill_next = '0;
        take_next = '0;
      end else begin
        take_next = take + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      take <= '0;
    end else begin
      fill <= fill_next;
      take <= take_next;
    end
  end

  // Storage is never cleared: only entries below the fill count are read.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[fill[AW-1:0]] <= req.wdata;
    end
    if (req.push && (fill[AW-1:0] == take_next[AW-1:0])) begin
      head_q <= req.wdata;
    end else begin
      head_q <= mem[take_next[AW-1:0]];
    end
  end

  assign stat.empty    = (fill == '0);
  assign stat.full     = (fill == CW'(RX_DEPTH));
  assign stat.one_left = one_left;
  assign stat.head     = head_q;

  a_take_below_fill: assert property (@(posedge clk) disable iff (rst)
    (fill != '0) |-> (take < fill))
    else $error("rx fifo take count not below fill count");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(RX_DEPTH))
    else $error("rx fifo fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req.push && !req.clear) |=> (fill == $past(fill) + CW'(1)))
    else $error("rx fifo push did not advance fill count");

endmodule

`default_nettype wire

### hw/rtl/u16550_regs.sv
// Register block of the UART: divisor latch, IER, LCR, MCR and scratch,
// read multiplexer, FIFO requests and interrupt recomputation per access.
// Depends on u16550_pkg.
`default_nettype none

module u16550_regs (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    step,
  input  wire                    func,
  input  wire  [2:0]             offset,
  input  wire  [7:0]             write_data,
  input  u16550_pkg::fifo_stat_t fifo_stat,
  output u16550_pkg::fifo_req_t  fifo_req,
  output u16550_pkg::result_t    result
);

  logic [15:0] divisor_latch;
  logic [3:0]  irq_enable;
  logic [7:0]  line_ctrl;
  logic [7:0]  modem_ctrl;
  logic [7:0]  scratch_reg;

  logic       is_wr;
  logic       dlab;
  logic       loop;
  logic       data_ready;
  logic [3:0] iir_now;
  logic [3:0] iir_after;
  logic [3:0] ier_after;
  logic       dr_after;
  logic       push_c;
  logic       pop_c;
  logic       clear_c;
  logic       tx_c;
  logic [7:0] rd;

  assign is_wr      = (func == u16550_pkg::FUNC_WRITE);
  assign dlab       = line_ctrl[u16550_pkg::LCR_DLAB_BIT];
  assign loop       = modem_ctrl[u16550_pkg::MCR_LOOP_BIT];
  assign data_ready = !fifo_stat.empty;

  assign push_c  = is_wr && (offset == u16550_pkg::OFS_RBR) && !dlab && loop && !fifo_stat.full;
  assign tx_c    = is_wr && (offset == u16550_pkg::OFS_RBR) && !dlab && !loop;
  assign pop_c   = !is_wr && (offset == u16550_pkg::OFS_RBR) && !dlab && data_ready;
  assign clear_c = is_wr && (offset == u16550_pkg::OFS_IIR)
                   && write_data[u16550_pkg::FCR_CLR_RX_BIT];

  // The transmitter is always empty, so only the enables and data ready matter.
  always_comb begin
    if (irq_enable[u16550_pkg::IER_RX_BIT] && data_ready) begin
      iir_now = u16550_pkg::IIR_RX;
    end else if (irq_enable[u16550_pkg::IER_TX_BIT]) begin
      iir_now = u16550_pkg::IIR_TX;
    end else begin
      iir_now = u16550_pkg::IIR_NONE;
    end
  end

  always_comb begin
    case (offset)
      u16550_pkg::OFS_RBR: rd = dlab ? divisor_latch[7:0]
                                     : (data_ready ? fifo_stat.head : 8'h00);
      u16550_pkg::OFS_IER: rd = dlab ? divisor_latch[15:8] : {4'h0, irq_enable};
      u16550_pkg::OFS_IIR: rd = u16550_pkg::IIR_FIXED | {4'h0, iir_now};
      u16550_pkg::OFS_LCR: rd = line_ctrl;
      u16550_pkg::OFS_MCR: rd = modem_ctrl;
      u16550_pkg::OFS_LSR: rd = u16550_pkg::LSR_TEMT_THRE | {7'h00, data_ready};
      u16550_pkg::OFS_MSR: rd = u16550_pkg::MSR_FIXED;
      u16550_pkg::OFS_SCR: rd = scratch_reg;
      default:             rd = 8'h00;
    endcase
  end

  // State as it stands once this access has been served.
  always_comb begin
    ier_after = irq_enable;
    if (is_wr && (offset == u16550_pkg::OFS_IER) && !dlab) begin
      ier_after = write_data[3:0];
    end
    if (push_c) begin
      dr_after = 1'b1;
    end else if (clear_c) begin
      dr_after = 1'b0;
    end else if (pop_c && fifo_stat.one_left) begin
      dr_after = 1'b0;
    end else begin
      dr_after = data_ready;
    end
    if (ier_after[u16550_pkg::IER_RX_BIT] && dr_after) begin
      iir_after = u16550_pkg::IIR_RX;
    end else if (ier_after[u16550_pkg::IER_TX_BIT]) begin
      iir_after = u16550_pkg::IIR_TX;
    end else begin
      iir_after = u16550_pkg::IIR_NONE;
    end
  end

  assign result.read_data = is_wr ? 8'h00 : rd;
  assign result.tx_valid  = tx_c;
  assign result.tx_byte   = tx_c ? write_data : 8'h00;
  assign result.irq_level = (iir_after != u16550_pkg::IIR_NONE);

  assign fifo_req.push  = step && push_c;
  assign fifo_req.pop   = step && pop_c;
  assign fifo_req.clear = step && clear_c;
  assign fifo_req.wdata = write_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_latch <= '0;
      irq_enable    <= '0;
      line_ctrl     <= '0;
      modem_ctrl    <= u16550_pkg::MCR_RESET;
      scratch_reg   <= '0;
    end else if (step && is_wr) begin
      case (offset)
        u16550_pkg::OFS_RBR: begin
          if (dlab) divisor_latch[7:0] <= write_data;
        end
        u16550_pkg::OFS_IER: begin
          if (dlab) divisor_latch[15:8] <= write_data;
          else      irq_enable <= write_data[3:0];
        end
        u16550_pkg::OFS_LCR: line_ctrl   <= write_data;
        u16550_pkg::OFS_MCR: modem_ctrl  <= write_data;
        u16550_pkg::OFS_SCR: scratch_reg <= write_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/uart_16550_register_model_core.sv
// Top level of the 16550-style UART register file.
// Input register, result register and stream handshake around u16550_regs
// and u16550_rx_fifo. Depends on u16550_pkg.
//
// Use of the block:
// Each item on the slave stream is one byte-wide bus access: tuser carries
// the access kind (read or write), tdata the register offset and the byte
// written. Every item gives exactly one item on the master stream with the
// byte read (zero on writes), the transmitted byte and its valid flag, and
// the interrupt line level after the access.
// Reads return register contents as they stood before the access.
// An accepted item is first held in the input register, then served by the
// register logic and written to the result register that drives the master
// stream. Throughput is one item per cycle while the master side accepts; the
// rate rests on the single register/FIFO update done per cycle, with the FIFO
// head entry read ahead from its memory into a register.
// When the receiver stalls, the result register holds its item and the
// input register keeps one more; s_axis_tready then falls until the master
// side moves again. Nothing is lost or repeated.
// Reset clears the divisor latch, IER, LCR, scratch, the receive FIFO counts and
// both stage valid flags at once, and sets MCR to its reset value. FIFO storage
// is not swept: entries are only read once written, so no clearing pass is needed.
`default_nettype none

module uart_16550_register_model_core #(
  parameter int RX_DEPTH = u16550_pkg::RX_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,  // offset[2:0], write_data[10:3], zero[15:11]
  input  wire         s_axis_tuser,  // func[0]: 0 read, 1 write
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata   // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                     // irq_level[17], zero[23:18]
);

  logic       in_valid;
  logic       in_func;
  logic [2:0] in_offset;
  logic [7:0] in_wdata;
  logic       step;

  u16550_pkg::fifo_req_t  fifo_req;
  u16550_pkg::fifo_stat_t fifo_stat;
  u16550_pkg::result_t    result;
  u16550_pkg::result_t    out_result;

  // An access is served when the result register is free or being emptied.
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func   <= s_axis_tuser;
      in_offset <= s_axis_tdata[2:0];
      in_wdata  <= s_axis_tdata[10:3];
    end
  end

  u16550_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .func       (in_func),
    .offset     (in_offset),
    .write_data (in_wdata),
    .fifo_stat  (fifo_stat),
    .fifo_req   (fifo_req),
    .result     (result)
  );

  u16550_rx_fifo #(
    .RX_DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk  (clk),
    .rst  (rst),
    .req  (fifo_req),
    .stat (fifo_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {6'h00, out_result.irq_level, out_result.tx_byte,
                         out_result.tx_valid, out_result.read_data};

endmodule

`default_nettype wire
